[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the LRU tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRUT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRUT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/lrut_pkg.sv]
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared sizes, register map, sequencer states and compare-unit types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrut_pkg;

  localparam int DEPTH  = 64;
  localparam int KEY_W  = 32;
  localparam int OUT_W  = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int CAP_W  = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [ADDR_W-3:0] REG_IDX_CAPACITY = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_UPDATE,
    ST_INSERT
  } state_e;

  typedef struct packed {
    logic             all;
    logic             is_tgt;
    logic [IDX_W-1:0] limit;
    logic [IDX_W-1:0] oldest;
  } cmp_req_t;

  typedef struct packed {
    logic             key_match;
    logic             is_oldest;
    logic [IDX_W-1:0] rank_next;
  } cmp_res_t;

endpackage

[rtl/core/lrut_ram.sv]
// ----------------------------------------------------------------------------
// lrut_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrut_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lrut_cmp_unit.sv]
// ----------------------------------------------------------------------------
// lrut_cmp_unit
// Shared key compare, oldest-rank detect and next-rank select (clear, increment or hold) for one slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrut_cmp_unit (
  input  logic [lrut_pkg::KEY_W-1:0] slot_key_i,
  input  logic [lrut_pkg::KEY_W-1:0] search_key_i,
  input  logic [lrut_pkg::IDX_W-1:0] slot_rank_i,
  input  lrut_pkg::cmp_req_t         req_i,
  output lrut_pkg::cmp_res_t         res_o
);

  logic bump;

  assign bump = req_i.all || (slot_rank_i < req_i.limit);

  always_comb begin
    res_o.key_match = (slot_key_i == search_key_i);
    res_o.is_oldest = (slot_rank_i == req_i.oldest);
    if (req_i.is_tgt) begin
      res_o.rank_next = '0;
    end else if (bump) begin
      res_o.rank_next = slot_rank_i + lrut_pkg::IDX_W'(1);
    end else begin
      res_o.rank_next = slot_rank_i;
    end
  end

endmodule

[rtl/core/lru_replacement_tracker_core.sv]
// Requests: taken only in idle; the key and rank memories are swept through their
//   single read port to search, and the rank memory is swept again to re-rank.
// Reset: clears resident count and output valid, capacity returns to 64; the
//   memories are not cleared, since only occupied slots are ever read.
// ----------------------------------------------------------------------------
// lru_replacement_tracker_core
// Fully associative LRU residency tracker with a sequential search/re-rank engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_replacement_tracker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // access requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   access_key_i,
  // events
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_kind_o,
  output logic [31:0]                   event_key_o,
  output logic                          last_of_run_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrut_pkg::ADDR_W-1:0]   paddr,
  input  logic [lrut_pkg::DATA_W-1:0]   pwdata,
  output logic [lrut_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  lrut_pkg::state_e state_q, state_d;

  logic [lrut_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic [lrut_pkg::CNT_W-1:0] count_q, count_d;
  logic [lrut_pkg::CNT_W-1:0] idx_q, idx_d;       // next slot to read
  logic [lrut_pkg::CNT_W-1:0] run_n_q, run_n_d;   // slots in the current sweep
  logic                       rd_vld_q, rd_vld_d; // read data arrives this cycle
  logic [lrut_pkg::IDX_W-1:0] rd_idx_q, rd_idx_d;

  logic [lrut_pkg::KEY_W-1:0] key_q, key_d;
  logic                       hit_q, hit_d;
  logic [lrut_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [lrut_pkg::IDX_W-1:0] hit_rank_q, hit_rank_d;
  logic [lrut_pkg::IDX_W-1:0] vic_idx_q, vic_idx_d;
  logic [lrut_pkg::KEY_W-1:0] vic_key_q, vic_key_d;

  // re-rank control
  logic [lrut_pkg::IDX_W-1:0] tgt_idx_q, tgt_idx_d;
  logic [lrut_pkg::IDX_W-1:0] limit_q, limit_d;
  logic                       all_q, all_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       out_kind_q, out_kind_d;
  logic [lrut_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic                       out_last_q, out_last_d;

  // --------------------------------------------------------------------------
  // Memory and compare-unit wiring
  // --------------------------------------------------------------------------
  logic                       key_we, key_re;
  logic [lrut_pkg::IDX_W-1:0] key_waddr;
  logic [lrut_pkg::KEY_W-1:0] key_rdata;
  logic                       rank_we, rank_re;
  logic [lrut_pkg::IDX_W-1:0] rank_rdata;
  logic [lrut_pkg::IDX_W-1:0] rd_addr;

  lrut_pkg::cmp_req_t cmp_req;
  lrut_pkg::cmp_res_t cmp_res;

  logic                       issue;
  logic                       pass_done;
  logic                       out_free;
  logic                       not_full;
  logic                       cfg_wr;
  logic [lrut_pkg::CNT_W-1:0] cap_eff;

  lrut_ram #(
    .Width(lrut_pkg::KEY_W),
    .Depth(lrut_pkg::DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_q),
    .re_i   (key_re),
    .raddr_i(rd_addr),
    .rdata_o(key_rdata)
  );

  lrut_ram #(
    .Width(lrut_pkg::IDX_W),
    .Depth(lrut_pkg::DEPTH)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rank_we),
    .waddr_i(rd_idx_q),
    .wdata_i(cmp_res.rank_next),
    .re_i   (rank_re),
    .raddr_i(rd_addr),
    .rdata_o(rank_rdata)
  );

  assign cmp_req.all    = all_q;
  assign cmp_req.is_tgt = (rd_idx_q == tgt_idx_q);
  assign cmp_req.limit  = limit_q;
  assign cmp_req.oldest = lrut_pkg::IDX_W'(count_q - lrut_pkg::CNT_W'(1));

  lrut_cmp_unit u_cmp_unit (
    .slot_key_i  (key_rdata),
    .search_key_i(key_q),
    .slot_rank_i (rank_rdata),
    .req_i       (cmp_req),
    .res_o       (cmp_res)
  );

  // --------------------------------------------------------------------------
  // Sweep bookkeeping and capacity clamp
  // --------------------------------------------------------------------------
  // Issue one slot read per cycle; the read data comes back in the next cycle.
  assign issue     = ((state_q == lrut_pkg::ST_SCAN) || (state_q == lrut_pkg::ST_UPDATE)) &&
                     (idx_q < run_n_q);
  assign rd_addr   = idx_q[lrut_pkg::IDX_W-1:0];
  assign pass_done = (idx_q == run_n_q) && !rd_vld_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // A capacity of zero acts as one; anything above DEPTH acts as DEPTH.
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = lrut_pkg::CNT_W'(1);
    end else if (32'(capacity_q) > lrut_pkg::DEPTH) begin
      cap_eff = lrut_pkg::CNT_W'(lrut_pkg::DEPTH);
    end else begin
      cap_eff = lrut_pkg::CNT_W'(capacity_q);
    end
  end

  assign not_full = (count_q < cap_eff);

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[lrut_pkg::ADDR_W-1:2] == lrut_pkg::REG_IDX_CAPACITY);
  assign prdata = (paddr[lrut_pkg::ADDR_W-1:2] == lrut_pkg::REG_IDX_CAPACITY) ?
                  lrut_pkg::DATA_W'(capacity_q) : '0;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrut_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lrut_pkg::ST_SCAN;
      end
      lrut_pkg::ST_SCAN: begin
        if (pass_done) state_d = lrut_pkg::ST_DECIDE;
      end
      lrut_pkg::ST_DECIDE: begin
        if (hit_q || not_full) begin
          state_d = lrut_pkg::ST_UPDATE;
        end else begin
          state_d = lrut_pkg::ST_EVICT;
        end
      end
      lrut_pkg::ST_EVICT: begin
        if (out_free) state_d = lrut_pkg::ST_UPDATE;
      end
      lrut_pkg::ST_UPDATE: begin
        if (pass_done) state_d = lrut_pkg::ST_INSERT;
      end
      lrut_pkg::ST_INSERT: begin
        if (out_free) state_d = lrut_pkg::ST_IDLE;
      end
      default: state_d = lrut_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    capacity_d  = cfg_wr ? pwdata[lrut_pkg::CAP_W-1:0] : capacity_q;
    count_d     = count_q;
    idx_d       = issue ? idx_q + lrut_pkg::CNT_W'(1) : idx_q;
    run_n_d     = run_n_q;
    rd_vld_d    = issue;
    rd_idx_d    = issue ? rd_addr : rd_idx_q;
    key_d       = key_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    vic_idx_d   = vic_idx_q;
    vic_key_d   = vic_key_q;
    tgt_idx_d   = tgt_idx_q;
    limit_d     = limit_q;
    all_d       = all_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_key_d   = out_key_q;
    out_last_d  = out_last_q;
    key_we      = 1'b0;
    key_waddr   = vic_idx_q;
    key_re      = 1'b0;
    rank_re     = 1'b0;
    rank_we     = 1'b0;

    unique case (state_q)
      lrut_pkg::ST_IDLE: begin
        // latch the request and arm a search over the resident slots
        if (in_valid_i) begin
          key_d   = lrut_pkg::KEY_W'(access_key_i);
          idx_d   = '0;
          run_n_d = count_q;
          hit_d   = 1'b0;
        end
      end
      lrut_pkg::ST_SCAN: begin
        key_re  = issue;
        rank_re = issue;
        if (rd_vld_q) begin
          // keep the first matching slot
          if (cmp_res.key_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_rank_d = rank_rdata;
          end
          if (cmp_res.is_oldest) begin
            vic_idx_d = rd_idx_q;
            vic_key_d = key_rdata;
          end
        end
      end
      lrut_pkg::ST_DECIDE: begin
        idx_d = '0;
        if (hit_q) begin
          // hit: bump only the ranks newer than the hit slot
          all_d     = 1'b0;
          limit_d   = hit_rank_q;
          tgt_idx_d = hit_idx_q;
          run_n_d   = count_q;
        end else if (not_full) begin
          // fill the next free slot
          key_we    = 1'b1;
          key_waddr = count_q[lrut_pkg::IDX_W-1:0];
          all_d     = 1'b1;
          tgt_idx_d = count_q[lrut_pkg::IDX_W-1:0];
          count_d   = count_q + lrut_pkg::CNT_W'(1);
          run_n_d   = count_q + lrut_pkg::CNT_W'(1);
        end else begin
          // full: the oldest slot gets replaced
          all_d     = 1'b1;
          tgt_idx_d = vic_idx_q;
          run_n_d   = count_q;
        end
      end
      lrut_pkg::ST_EVICT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b1;
          out_key_d   = vic_key_q;
          out_last_d  = 1'b0;
          key_we      = 1'b1;
          key_waddr   = vic_idx_q;
        end
      end
      lrut_pkg::ST_UPDATE: begin
        rank_re = issue;
        rank_we = rd_vld_q;
      end
      lrut_pkg::ST_INSERT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b0;
          out_key_d   = key_q;
          out_last_d  = 1'b1;
        end
      end
      default: begin
        rd_vld_d = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrut_pkg::ST_IDLE;
      capacity_q  <= lrut_pkg::CAP_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      run_n_q     <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      all_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      capacity_q  <= capacity_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      run_n_q     <= run_n_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      all_q       <= all_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    key_q      <= key_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    vic_idx_q  <= vic_idx_d;
    vic_key_q  <= vic_key_d;
    tgt_idx_q  <= tgt_idx_d;
    limit_q    <= limit_d;
    out_kind_q <= out_kind_d;
    out_key_q  <= out_key_d;
    out_last_q <= out_last_d;
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign in_ready_o    = (state_q == lrut_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign event_key_o   = lrut_pkg::OUT_W'(out_key_q);
  assign last_of_run_o = out_last_q;

endmodule

[rtl/core/lrut_checker.sv]
// ----------------------------------------------------------------------------
// lrut_checker
// Port-level checks on the LRU tracker: sequencing and event framing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrut_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        event_kind_o,
  input logic [31:0] event_key_o,
  input logic        last_of_run_o
);

  // the engine is busy right after it takes a request
  `LRUT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // an eviction is never the final event of an access
  `LRUT_ASSERT(a_evict_not_last, out_valid_o && event_kind_o, !last_of_run_o)
  // an insert or touch always closes the access
  `LRUT_ASSERT(a_insert_is_last, out_valid_o && !event_kind_o, last_of_run_o)
  // a stalled event holds its key
  `LRUT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(event_key_o))

endmodule

bind lru_replacement_tracker_core lrut_checker u_lrut_checker (.*);
